// File: sv/cst_pkg.sv
// ----------------------------------------------------------------------------
// cst_pkg: shared definitions for the class seat table allocator
// Widths, status and mode codes, register indexes, handshake structs between
// the sequencer and the remainder unit, and the seat score function.
// ----------------------------------------------------------------------------
package cst_pkg;

   localparam int MAX_SEATS = 64;
   localparam int IDX_W     = (MAX_SEATS > 1) ? $clog2(MAX_SEATS) : 1;
   localparam int CNT_W     = $clog2(MAX_SEATS + 1);

   localparam int MODE_W    = 2;
   localparam int INDEX_W   = 6;
   localparam int ID_W      = 16;
   localparam int CLASS_W   = 2;
   localparam int COL_W     = 8;
   localparam int STATUS_W  = 2;
   localparam int ACT_W     = 7;
   localparam int SPR_W     = 5;
   localparam int RES_W     = ID_W + 1;
   localparam int SCORE_W   = 7;
   localparam int REM_CNT_W = $clog2(COL_W);

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // register indexes, decoded from the word address
   localparam logic REG_ACTIVE_COUNT  = 1'b0;
   localparam logic REG_SEATS_PER_ROW = 1'b1;

   localparam logic [ACT_W-1:0] ACTIVE_COUNT_RESET  = 7'd0;
   localparam logic [SPR_W-1:0] SEATS_PER_ROW_RESET = 5'd6;

   // first column character
   localparam logic [COL_W-1:0] COL_BASE = 8'h41;

   // no seat found
   localparam logic signed [RES_W-1:0] NONE_ID = {RES_W{1'b1}};

   localparam logic [STATUS_W-1:0] STATUS_FREE     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OCCUPIED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RESERVED = 2'd2;

   typedef enum logic [MODE_W-1:0] {
      MODE_LOAD    = 2'd0,
      MODE_RESERVE = 2'd1,
      MODE_RELEASE = 2'd2,
      MODE_QUERY   = 2'd3
   } mode_type;

   typedef enum logic [3:0] {
      SEQ_IDLE,
      SEQ_FIND_RD,
      SEQ_FIND_CHK,
      SEQ_SCAN_RD,
      SEQ_SCAN_CHK,
      SEQ_SCAN_DIV,
      SEQ_UNIQ_RUN,
      SEQ_UNIQ_DRAIN,
      SEQ_FINISH
   } seq_state_type;

   typedef struct packed {
      logic [ID_W-1:0]     id;
      logic [CLASS_W-1:0]  cls;
      logic [COL_W-1:0]    col;
      logic [STATUS_W-1:0] status;
   } entry_type;

   typedef struct packed {
      logic [CNT_W-1:0] used;
      logic [SPR_W-1:0] spr;
   } cfg_type;

   typedef struct packed {
      logic             start;
      logic [COL_W-1:0] dividend;
      logic [SPR_W-1:0] divisor;
   } rem_req_type;

   typedef struct packed {
      logic             done;
      logic [SPR_W-1:0] rem;
   } rem_rsp_type;

   // spr - |pos - spr/2|, pos carries the sign of the column offset
   function automatic logic signed [SCORE_W-1:0] seat_score(
      input logic             neg,
      input logic [SPR_W-1:0] rem,
      input logic [SPR_W-1:0] spr
   );
      logic signed [SCORE_W-1:0] mag;
      logic signed [SCORE_W-1:0] pos;
      logic signed [SCORE_W-1:0] half;
      logic signed [SCORE_W-1:0] dev;
      logic signed [SCORE_W-1:0] width;
      mag   = $signed({{(SCORE_W-SPR_W){1'b0}}, rem});
      pos   = neg ? -mag : mag;
      half  = $signed({{(SCORE_W-SPR_W+1){1'b0}}, spr[SPR_W-1:1]});
      width = $signed({{(SCORE_W-SPR_W){1'b0}}, spr});
      dev   = pos - half;
      if (dev < 0) begin
         dev = -dev;
      end
      return width - dev;
   endfunction

endpackage

// File: sv/class_seat_table_allocator_unit.sv
// flow: a reserve/release first walks the entries for its id; every item then scans the
//   active entries (remainder for each free entry of the asked class while seats per row
//   is nonzero) and compares the ids pairwise; with no active entry nothing is walked
// throughput: one item at a time, set by the pairwise id compare over the table read ports
// reset: control state clears, active_count 0, seats_per_row 6; table contents stay undefined
//   until loaded, no clearing pass
// ----------------------------------------------------------------------------
// class_seat_table_allocator_unit: seat table with reserve, release and search
// Holds the seat table, takes load/reserve/release/query beats and returns
// one result beat with search results, status counts and an id check.
// ----------------------------------------------------------------------------
module class_seat_table_allocator_unit (
   input  logic                             clock,
   input  logic                             reset,
   // item channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [cst_pkg::MODE_W-1:0]       req_mode,
   input  logic [cst_pkg::INDEX_W-1:0]      req_entry_index,
   input  logic [cst_pkg::ID_W-1:0]         req_seat_id,
   input  logic [cst_pkg::CLASS_W-1:0]      req_class_code,
   input  logic [cst_pkg::COL_W-1:0]        req_column_code,
   input  logic [cst_pkg::STATUS_W-1:0]     req_status_code,
   // result channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_ok,
   output logic signed [cst_pkg::RES_W-1:0] rsp_first_free_id,
   output logic signed [cst_pkg::RES_W-1:0] rsp_best_free_id,
   output logic [cst_pkg::ACT_W-1:0]        rsp_free_total,
   output logic [cst_pkg::ACT_W-1:0]        rsp_occupied_total,
   output logic [cst_pkg::ACT_W-1:0]        rsp_reserved_total,
   output logic                             rsp_ids_unique,
   // register port
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [cst_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [cst_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [cst_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready
);
   import cst_pkg::*;

   // configuration registers
   logic [ACT_W-1:0] active_count_ff, active_count_in;
   logic [SPR_W-1:0] seats_per_row_ff, seats_per_row_in;
   logic             csr_write;
   logic             csr_index;
   cfg_type          cfg;

   // table and remainder unit hookup
   logic             tbl_we;
   logic [IDX_W-1:0] tbl_waddr;
   entry_type        tbl_wdata;
   logic [IDX_W-1:0] tbl_raddr_a;
   logic [IDX_W-1:0] tbl_raddr_b;
   entry_type        tbl_rdata_a;
   entry_type        tbl_rdata_b;
   rem_req_type      rem_req;
   rem_rsp_type      rem_rsp;

   // no wait states; the word index sits above the byte offset
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[CSR_ADDR_W-1];

   always_comb begin
      active_count_in  = active_count_ff;
      seats_per_row_in = seats_per_row_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_ACTIVE_COUNT:  active_count_in  = pwdata[ACT_W-1:0];
            REG_SEATS_PER_ROW: seats_per_row_in = pwdata[SPR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_ACTIVE_COUNT:  prdata = CSR_DATA_W'(active_count_ff);
         REG_SEATS_PER_ROW: prdata = CSR_DATA_W'(seats_per_row_ff);
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_count_ff  <= ACTIVE_COUNT_RESET;
         seats_per_row_ff <= SEATS_PER_ROW_RESET;
      end else begin
         active_count_ff  <= active_count_in;
         seats_per_row_ff <= seats_per_row_in;
      end
   end

   // active count beyond the table saturates to the table size
   assign cfg.used = (int'(active_count_ff) > MAX_SEATS) ? CNT_W'(MAX_SEATS)
                                                          : CNT_W'(active_count_ff);
   assign cfg.spr  = seats_per_row_ff;

   cst_table u_table (
      .clock   (clock),
      .we      (tbl_we),
      .waddr   (tbl_waddr),
      .wdata   (tbl_wdata),
      .raddr_a (tbl_raddr_a),
      .raddr_b (tbl_raddr_b),
      .rdata_a (tbl_rdata_a),
      .rdata_b (tbl_rdata_b)
   );

   // shared remainder unit for the seat position
   cst_rem u_rem (
      .clock (clock),
      .reset (reset),
      .req   (rem_req),
      .rsp   (rem_rsp)
   );

   cst_seq u_seq (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_mode           (req_mode),
      .req_entry_index    (req_entry_index),
      .req_seat_id        (req_seat_id),
      .req_class_code     (req_class_code),
      .req_column_code    (req_column_code),
      .req_status_code    (req_status_code),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_ok             (rsp_ok),
      .rsp_first_free_id  (rsp_first_free_id),
      .rsp_best_free_id   (rsp_best_free_id),
      .rsp_free_total     (rsp_free_total),
      .rsp_occupied_total (rsp_occupied_total),
      .rsp_reserved_total (rsp_reserved_total),
      .rsp_ids_unique     (rsp_ids_unique),
      .tbl_we             (tbl_we),
      .tbl_waddr          (tbl_waddr),
      .tbl_wdata          (tbl_wdata),
      .tbl_raddr_a        (tbl_raddr_a),
      .tbl_raddr_b        (tbl_raddr_b),
      .tbl_rdata_a        (tbl_rdata_a),
      .tbl_rdata_b        (tbl_rdata_b),
      .rem_req            (rem_req),
      .rem_rsp            (rem_rsp)
   );

endmodule

// File: sv/cst_table.sv
// ----------------------------------------------------------------------------
// cst_table: seat entry memory
// One write port and two read ports, read data registered. No reset: an
// entry holds garbage until it is loaded.
// ----------------------------------------------------------------------------
module cst_table (
   input  logic                          clock,
   input  logic                          we,
   input  logic [cst_pkg::IDX_W-1:0]     waddr,
   input  cst_pkg::entry_type            wdata,
   input  logic [cst_pkg::IDX_W-1:0]     raddr_a,
   input  logic [cst_pkg::IDX_W-1:0]     raddr_b,
   output cst_pkg::entry_type            rdata_a,
   output cst_pkg::entry_type            rdata_b
);
   import cst_pkg::*;

   entry_type mem [MAX_SEATS];
   entry_type rdata_a_ff;
   entry_type rdata_b_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_a_ff <= mem[raddr_a];
      rdata_b_ff <= mem[raddr_b];
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

// File: sv/cst_rem.sv
// ----------------------------------------------------------------------------
// cst_rem: iterative remainder unit
// Restoring remainder of the column offset by seats per row, one dividend
// bit per cycle; done pulses for one cycle with the remainder.
// ----------------------------------------------------------------------------
module cst_rem (
   input  logic                 clock,
   input  logic                 reset,
   input  cst_pkg::rem_req_type req,
   output cst_pkg::rem_rsp_type rsp
);
   import cst_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [REM_CNT_W-1:0] cnt_ff, cnt_in;
   logic [COL_W-1:0]     quo_ff, quo_in;
   logic [SPR_W-1:0]     rem_ff, rem_in;
   logic [SPR_W-1:0]     div_ff, div_in;
   logic [SPR_W:0]       trial;

   assign trial = {rem_ff, quo_ff[COL_W-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = req.dividend;
         rem_in  = '0;
         div_in  = req.divisor;
      end else if (busy_ff) begin
         // trial subtract, remainder stays below the divisor
         if (trial >= {1'b0, div_ff}) begin
            rem_in = SPR_W'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[SPR_W-1:0];
         end
         quo_in = {quo_ff[COL_W-2:0], 1'b0};
         cnt_in = cnt_ff + REM_CNT_W'(1);
         if (cnt_ff == REM_CNT_W'(COL_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign rsp.done = done_ff;
   assign rsp.rem  = rem_ff;

endmodule

// File: sv/cst_seq.sv
// ----------------------------------------------------------------------------
// cst_seq: item sequencer
// Walks the table for id lookup, status counts and seat search, runs the
// pairwise id compare, and holds the result beat in an output register.
// ----------------------------------------------------------------------------
module cst_seq (
   input  logic                           clock,
   input  logic                           reset,
   input  cst_pkg::cfg_type               cfg,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [cst_pkg::MODE_W-1:0]     req_mode,
   input  logic [cst_pkg::INDEX_W-1:0]    req_entry_index,
   input  logic [cst_pkg::ID_W-1:0]       req_seat_id,
   input  logic [cst_pkg::CLASS_W-1:0]    req_class_code,
   input  logic [cst_pkg::COL_W-1:0]      req_column_code,
   input  logic [cst_pkg::STATUS_W-1:0]   req_status_code,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_ok,
   output logic signed [cst_pkg::RES_W-1:0] rsp_first_free_id,
   output logic signed [cst_pkg::RES_W-1:0] rsp_best_free_id,
   output logic [cst_pkg::ACT_W-1:0]      rsp_free_total,
   output logic [cst_pkg::ACT_W-1:0]      rsp_occupied_total,
   output logic [cst_pkg::ACT_W-1:0]      rsp_reserved_total,
   output logic                           rsp_ids_unique,
   output logic                           tbl_we,
   output logic [cst_pkg::IDX_W-1:0]      tbl_waddr,
   output cst_pkg::entry_type             tbl_wdata,
   output logic [cst_pkg::IDX_W-1:0]      tbl_raddr_a,
   output logic [cst_pkg::IDX_W-1:0]      tbl_raddr_b,
   input  cst_pkg::entry_type             tbl_rdata_a,
   input  cst_pkg::entry_type             tbl_rdata_b,
   output cst_pkg::rem_req_type           rem_req,
   input  cst_pkg::rem_rsp_type           rem_rsp
);
   import cst_pkg::*;

   seq_state_type state_ff, state_in;

   mode_type               mode_ff, mode_in;
   logic [ID_W-1:0]        id_ff, id_in;
   logic [CLASS_W-1:0]     cls_ff, cls_in;
   logic [CNT_W-1:0]       i_ff, i_in;
   logic [CNT_W-1:0]       j_ff, j_in;
   logic                   ok_ff, ok_in;
   logic                   have_first_ff, have_first_in;
   logic                   uniq_ff, uniq_in;
   logic                   cmp_vld_ff, cmp_vld_in;
   logic                   neg_ff, neg_in;
   logic signed [RES_W-1:0]   first_ff, first_in;
   logic signed [RES_W-1:0]   best_ff, best_in;
   logic signed [SCORE_W-1:0] best_score_ff, best_score_in;
   logic [CNT_W-1:0]       nfree_ff, nfree_in;
   logic [CNT_W-1:0]       nocc_ff, nocc_in;
   logic [CNT_W-1:0]       nres_ff, nres_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_ok_ff, rsp_ok_in;
   logic signed [RES_W-1:0] rsp_first_ff, rsp_first_in;
   logic signed [RES_W-1:0] rsp_best_ff, rsp_best_in;
   logic [ACT_W-1:0]       rsp_free_ff, rsp_free_in;
   logic [ACT_W-1:0]       rsp_occ_ff, rsp_occ_in;
   logic [ACT_W-1:0]       rsp_res_ff, rsp_res_in;
   logic                   rsp_uniq_ff, rsp_uniq_in;

   logic                   accept;
   logic                   is_find;
   logic                   last_i;
   logic                   pair_last;
   logic                   id_hit;
   logic                   match;
   logic                   need_div;
   logic                   dup;
   logic                   can_out;
   logic                   entry_done;
   logic [STATUS_W-1:0]    from_st;
   logic [STATUS_W-1:0]    to_st;
   logic                   diff_neg;
   logic [COL_W-1:0]       diff_mag;
   logic signed [SCORE_W-1:0] score;
   logic signed [RES_W-1:0]   entry_id;
   logic [CNT_W-1:0]       used_m1;
   logic [CNT_W-1:0]       used_m2;
   entry_type              ent;

   assign ent       = tbl_rdata_a;
   assign accept    = req_valid && req_ready;
   assign is_find   = (mode_type'(req_mode) == MODE_RESERVE) ||
                      (mode_type'(req_mode) == MODE_RELEASE);
   assign used_m1   = cfg.used - CNT_W'(1);
   assign used_m2   = cfg.used - CNT_W'(2);
   assign last_i    = (i_ff == used_m1);
   assign pair_last = (j_ff == used_m1) && (i_ff == used_m2);
   assign id_hit    = (ent.id == id_ff);
   assign match     = (ent.status == STATUS_FREE) && (ent.cls == cls_ff);
   assign need_div  = match && (cfg.spr != '0);
   assign dup       = (tbl_rdata_a.id == tbl_rdata_b.id);
   assign can_out   = !rsp_valid_ff || rsp_ready;
   assign entry_done = ((state_ff == SEQ_SCAN_CHK) && !need_div) ||
                       ((state_ff == SEQ_SCAN_DIV) && rem_rsp.done);
   assign from_st   = (mode_ff == MODE_RESERVE) ? STATUS_FREE : STATUS_RESERVED;
   assign to_st     = (mode_ff == MODE_RESERVE) ? STATUS_RESERVED : STATUS_FREE;
   assign diff_neg  = (ent.col < COL_BASE);
   assign diff_mag  = diff_neg ? (COL_BASE - ent.col) : (ent.col - COL_BASE);
   assign score     = seat_score(neg_ff, rem_rsp.rem, cfg.spr);
   assign entry_id  = $signed({1'b0, ent.id});

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SEQ_IDLE: begin
            if (accept) begin
               if (cfg.used == '0) begin
                  state_in = SEQ_FINISH;
               end else if (is_find) begin
                  state_in = SEQ_FIND_RD;
               end else begin
                  state_in = SEQ_SCAN_RD;
               end
            end
         end
         SEQ_FIND_RD: begin
            state_in = SEQ_FIND_CHK;
         end
         SEQ_FIND_CHK: begin
            if (id_hit || last_i) begin
               state_in = SEQ_SCAN_RD;
            end else begin
               state_in = SEQ_FIND_RD;
            end
         end
         SEQ_SCAN_RD: begin
            state_in = SEQ_SCAN_CHK;
         end
         SEQ_SCAN_CHK, SEQ_SCAN_DIV: begin
            if ((state_ff == SEQ_SCAN_CHK) && need_div) begin
               state_in = SEQ_SCAN_DIV;
            end else if (entry_done) begin
               if (!last_i) begin
                  state_in = SEQ_SCAN_RD;
               end else if (cfg.used < CNT_W'(2)) begin
                  state_in = SEQ_FINISH;
               end else begin
                  state_in = SEQ_UNIQ_RUN;
               end
            end
         end
         SEQ_UNIQ_RUN: begin
            if (cmp_vld_ff && dup) begin
               state_in = SEQ_FINISH;
            end else if (pair_last) begin
               state_in = SEQ_UNIQ_DRAIN;
            end
         end
         SEQ_UNIQ_DRAIN: begin
            state_in = SEQ_FINISH;
         end
         SEQ_FINISH: begin
            if (can_out) begin
               state_in = SEQ_IDLE;
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      mode_in       = mode_ff;
      id_in         = id_ff;
      cls_in        = cls_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      ok_in         = ok_ff;
      have_first_in = have_first_ff;
      uniq_in       = uniq_ff;
      neg_in        = neg_ff;
      first_in      = first_ff;
      best_in       = best_ff;
      best_score_in = best_score_ff;
      nfree_in      = nfree_ff;
      nocc_in       = nocc_ff;
      nres_in       = nres_ff;
      cmp_vld_in    = (state_ff == SEQ_UNIQ_RUN);

      tbl_we        = 1'b0;
      tbl_waddr     = IDX_W'(req_entry_index);
      tbl_wdata     = '{id: req_seat_id, cls: req_class_code,
                        col: req_column_code, status: req_status_code};

      rem_req.start    = (state_ff == SEQ_SCAN_CHK) && need_div;
      rem_req.dividend = diff_mag;
      rem_req.divisor  = cfg.spr;

      rsp_ok_in    = rsp_ok_ff;
      rsp_first_in = rsp_first_ff;
      rsp_best_in  = rsp_best_ff;
      rsp_free_in  = rsp_free_ff;
      rsp_occ_in   = rsp_occ_ff;
      rsp_res_in   = rsp_res_ff;
      rsp_uniq_in  = rsp_uniq_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      case (state_ff)
         SEQ_IDLE: begin
            if (accept) begin
               mode_in       = mode_type'(req_mode);
               id_in         = req_seat_id;
               cls_in        = req_class_code;
               i_in          = '0;
               have_first_in = 1'b0;
               uniq_in       = 1'b0;
               first_in      = NONE_ID;
               best_in       = NONE_ID;
               best_score_in = -SCORE_W'(1);
               nfree_in      = '0;
               nocc_in       = '0;
               nres_in       = '0;
               case (mode_type'(req_mode))
                  MODE_LOAD:  ok_in = 1'b1;
                  MODE_QUERY: ok_in = (cfg.used != '0);
                  default:    ok_in = 1'b0;
               endcase
               // a load is written at once, the scan reads it later
               if ((mode_type'(req_mode) == MODE_LOAD) &&
                   (int'(req_entry_index) < MAX_SEATS)) begin
                  tbl_we = 1'b1;
               end
            end
         end
         SEQ_FIND_CHK: begin
            if (id_hit && (ent.status == from_st)) begin
               tbl_we    = 1'b1;
               tbl_waddr = i_ff[IDX_W-1:0];
               tbl_wdata = '{id: ent.id, cls: ent.cls, col: ent.col, status: to_st};
               ok_in     = 1'b1;
            end
            if (id_hit || last_i) begin
               i_in = '0;
            end else begin
               i_in = i_ff + CNT_W'(1);
            end
         end
         SEQ_SCAN_CHK: begin
            case (ent.status)
               STATUS_FREE:     nfree_in = nfree_ff + CNT_W'(1);
               STATUS_OCCUPIED: nocc_in  = nocc_ff + CNT_W'(1);
               STATUS_RESERVED: nres_in  = nres_ff + CNT_W'(1);
               default:         ;
            endcase
            if (match && !have_first_ff) begin
               have_first_in = 1'b1;
               first_in      = entry_id;
            end
            neg_in = diff_neg;
         end
         SEQ_SCAN_DIV: begin
            // strict compare keeps the earliest entry on ties
            if (rem_rsp.done && (score > best_score_ff)) begin
               best_score_in = score;
               best_in       = entry_id;
            end
         end
         SEQ_UNIQ_RUN: begin
            if (cmp_vld_ff && dup) begin
               uniq_in = 1'b0;
            end
            if (j_ff == used_m1) begin
               i_in = i_ff + CNT_W'(1);
               j_in = i_ff + CNT_W'(2);
            end else begin
               j_in = j_ff + CNT_W'(1);
            end
         end
         SEQ_UNIQ_DRAIN: begin
            if (cmp_vld_ff && dup) begin
               uniq_in = 1'b0;
            end
         end
         SEQ_FINISH: begin
            if (can_out) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = ok_ff;
               rsp_first_in = first_ff;
               rsp_best_in  = best_ff;
               rsp_free_in  = ACT_W'(nfree_ff);
               rsp_occ_in   = ACT_W'(nocc_ff);
               rsp_res_in   = ACT_W'(nres_ff);
               rsp_uniq_in  = uniq_ff;
            end
         end
         default: ;
      endcase

      // step to the next entry, or set up the pair walk after the last one
      if (entry_done) begin
         if (last_i) begin
            i_in    = '0;
            j_in    = CNT_W'(1);
            uniq_in = 1'b1;
         end else begin
            i_in = i_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         rsp_valid_ff <= 1'b0;
         cmp_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cmp_vld_ff   <= cmp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      id_ff         <= id_in;
      cls_ff        <= cls_in;
      i_ff          <= i_in;
      j_ff          <= j_in;
      ok_ff         <= ok_in;
      have_first_ff <= have_first_in;
      uniq_ff       <= uniq_in;
      neg_ff        <= neg_in;
      first_ff      <= first_in;
      best_ff       <= best_in;
      best_score_ff <= best_score_in;
      nfree_ff      <= nfree_in;
      nocc_ff       <= nocc_in;
      nres_ff       <= nres_in;
      rsp_ok_ff     <= rsp_ok_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_best_ff   <= rsp_best_in;
      rsp_free_ff   <= rsp_free_in;
      rsp_occ_ff    <= rsp_occ_in;
      rsp_res_ff    <= rsp_res_in;
      rsp_uniq_ff   <= rsp_uniq_in;
   end

   assign req_ready          = (state_ff == SEQ_IDLE);
   assign tbl_raddr_a        = i_ff[IDX_W-1:0];
   assign tbl_raddr_b        = j_ff[IDX_W-1:0];
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_ok             = rsp_ok_ff;
   assign rsp_first_free_id  = rsp_first_ff;
   assign rsp_best_free_id   = rsp_best_ff;
   assign rsp_free_total     = rsp_free_ff;
   assign rsp_occupied_total = rsp_occ_ff;
   assign rsp_reserved_total = rsp_res_ff;
   assign rsp_ids_unique     = rsp_uniq_ff;

endmodule

// File: sv/cst_checker.sv
// ----------------------------------------------------------------------------
// cst_checker: port-level checks for the seat table allocator
// Watches the item and result channels and the result fields over time.
// ----------------------------------------------------------------------------
module cst_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic                             rsp_ok,
   input logic signed [cst_pkg::RES_W-1:0] rsp_first_free_id,
   input logic signed [cst_pkg::RES_W-1:0] rsp_best_free_id,
   input logic [cst_pkg::ACT_W-1:0]        rsp_free_total,
   input logic [cst_pkg::ACT_W-1:0]        rsp_occupied_total,
   input logic [cst_pkg::ACT_W-1:0]        rsp_reserved_total,
   input logic                             rsp_ids_unique
);
   import cst_pkg::*;

   // a stalled result beat holds: valid and every field but the occupied and reserved totals
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ok) &&
      $stable(rsp_first_free_id) && $stable(rsp_best_free_id) &&
      $stable(rsp_free_total) && $stable(rsp_ids_unique))
      else $error("result beat changed while stalled");

   // one item in flight
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted while busy");

   // status counts never exceed the table
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (9'(rsp_free_total) + 9'(rsp_occupied_total) +
                     9'(rsp_reserved_total)) <= 9'(MAX_SEATS))
      else $error("status totals exceed table size");

   // a best seat is always also a first seat
   a_best_has_first: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_best_free_id != NONE_ID) |-> rsp_first_free_id != NONE_ID)
      else $error("best seat without first seat");

   // a free seat found means the free count is nonzero
   a_first_has_free: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_first_free_id != NONE_ID) |-> rsp_free_total != '0)
      else $error("free seat reported with zero free total");

endmodule

bind class_seat_table_allocator_unit cst_checker u_cst_checker (.*);

// File: sim/seat_table_watch.sv
// ----------------------------------------------------------------------------
// seat_table_watch: result predictor and checker for the seat table allocator
// Mirrors the register writes and every accepted item into its own seat
// table, computes the result each item should give and compares it field by
// field with the result beats in arrival order.
// ----------------------------------------------------------------------------
module seat_table_watch (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  logic [cst_pkg::MODE_W-1:0]       req_mode,
   input  logic [cst_pkg::INDEX_W-1:0]      req_entry_index,
   input  logic [cst_pkg::ID_W-1:0]         req_seat_id,
   input  logic [cst_pkg::CLASS_W-1:0]      req_class_code,
   input  logic [cst_pkg::COL_W-1:0]        req_column_code,
   input  logic [cst_pkg::STATUS_W-1:0]     req_status_code,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic                             rsp_ok,
   input  logic signed [cst_pkg::RES_W-1:0] rsp_first_free_id,
   input  logic signed [cst_pkg::RES_W-1:0] rsp_best_free_id,
   input  logic [cst_pkg::ACT_W-1:0]        rsp_free_total,
   input  logic [cst_pkg::ACT_W-1:0]        rsp_occupied_total,
   input  logic [cst_pkg::ACT_W-1:0]        rsp_reserved_total,
   input  logic                             rsp_ids_unique,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic                             pready,
   input  logic [cst_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [cst_pkg::CSR_DATA_W-1:0]   pwdata,
   output int                               fail_count,
   output int                               backlog,
   output int                               compared
);
   import cst_pkg::*;

   typedef struct packed {
      mode_type            mode;
      logic [INDEX_W-1:0]  index;
      logic [ID_W-1:0]     id;
      logic [CLASS_W-1:0]  cls;
      logic [COL_W-1:0]    col;
      logic [STATUS_W-1:0] status;
   } seat_item_type;

   typedef struct packed {
      logic             ok;
      logic [RES_W-1:0] first_id;
      logic [RES_W-1:0] best_id;
      logic [ACT_W-1:0] free_n;
      logic [ACT_W-1:0] occ_n;
      logic [ACT_W-1:0] res_n;
      logic             uniq;
   } seat_answer_type;

   logic [ID_W-1:0]     seat_ids [MAX_SEATS];
   logic [CLASS_W-1:0]  seat_cls [MAX_SEATS];
   logic [COL_W-1:0]    seat_col [MAX_SEATS];
   logic [STATUS_W-1:0] seat_st  [MAX_SEATS];
   logic [ACT_W-1:0]    active_cfg;
   logic [SPR_W-1:0]    spr_cfg;

   seat_answer_type answers_due [$];
   int              misses = 0;
   int              compared_n = 0;

   // spr - |pos - spr/2|, pos keeps the sign of the column offset
   function automatic int column_score(logic [COL_W-1:0] col, int spr);
      int diff;
      int pos;
      int dev;
      diff = int'(col) - int'(COL_BASE);
      pos  = diff % spr;
      dev  = pos - spr / 2;
      if (dev < 0) begin
         dev = -dev;
      end
      return spr - dev;
   endfunction

   // first entry holding the id decides, later duplicates are never looked at
   function automatic logic shift_status(int n, logic [ID_W-1:0] id,
                                         logic [STATUS_W-1:0] from,
                                         logic [STATUS_W-1:0] to);
      for (int i = 0; i < n; i++) begin
         if (seat_ids[i] == id) begin
            if (seat_st[i] == from) begin
               seat_st[i] = to;
               return 1'b1;
            end
            return 1'b0;
         end
      end
      return 1'b0;
   endfunction

   task automatic step_table(input seat_item_type it, output seat_answer_type ans);
      int n;
      int spr;
      int sc;
      int best_sc;
      int nfree;
      int nocc;
      int nres;
      bit have_first;
      n = (int'(active_cfg) > MAX_SEATS) ? MAX_SEATS : int'(active_cfg);
      spr = int'(spr_cfg);
      ans = '0;
      ans.first_id = NONE_ID;
      ans.best_id = NONE_ID;
      case (it.mode)
         MODE_LOAD: begin
            seat_ids[it.index] = it.id;
            seat_cls[it.index] = it.cls;
            seat_col[it.index] = it.col;
            seat_st[it.index]  = it.status;
            ans.ok = 1'b1;
         end
         MODE_RESERVE: ans.ok = shift_status(n, it.id, STATUS_FREE, STATUS_RESERVED);
         MODE_RELEASE: ans.ok = shift_status(n, it.id, STATUS_RESERVED, STATUS_FREE);
         default:      ans.ok = (n > 0);
      endcase
      if (n > 0) begin
         best_sc = -1;
         have_first = 0;
         nfree = 0;
         nocc = 0;
         nres = 0;
         for (int i = 0; i < n; i++) begin
            if (seat_st[i] == STATUS_FREE) nfree++;
            else if (seat_st[i] == STATUS_OCCUPIED) nocc++;
            else if (seat_st[i] == STATUS_RESERVED) nres++;
            if (seat_st[i] == STATUS_FREE && seat_cls[i] == it.cls) begin
               if (!have_first) begin
                  have_first = 1;
                  ans.first_id = {1'b0, seat_ids[i]};
               end
               // negative scores never win, ties keep the earliest entry
               if (spr > 0) begin
                  sc = column_score(seat_col[i], spr);
                  if (sc > best_sc) begin
                     best_sc = sc;
                     ans.best_id = {1'b0, seat_ids[i]};
                  end
               end
            end
         end
         ans.free_n = nfree[ACT_W-1:0];
         ans.occ_n  = nocc[ACT_W-1:0];
         ans.res_n  = nres[ACT_W-1:0];
         ans.uniq   = 1'b1;
         for (int i = 0; i < n; i++) begin
            for (int j = i + 1; j < n; j++) begin
               if (seat_ids[i] == seat_ids[j]) ans.uniq = 1'b0;
            end
         end
      end
   endtask

   task automatic check_field(string name, logic [RES_W-1:0] want, logic [RES_W-1:0] got);
      if (got !== want) begin
         misses++;
         if (misses <= 10) begin
            $display("mismatch in result %0d, %s: expected %0h, got %0h",
                     compared_n, name, want, got);
         end
      end
   endtask

   always @(posedge clock) begin
      seat_item_type   it;
      seat_answer_type ans;
      if (reset) begin
         active_cfg = ACTIVE_COUNT_RESET;
         spr_cfg    = SEATS_PER_ROW_RESET;
         answers_due.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_SEATS_PER_ROW) spr_cfg = pwdata[SPR_W-1:0];
            else active_cfg = pwdata[ACT_W-1:0];
         end
         // results first, so a beat can never match the item taken at the same edge
         if (rsp_valid && rsp_ready) begin
            if (answers_due.size() == 0) begin
               misses++;
               if (misses <= 10) $display("result beat with nothing outstanding");
            end else begin
               ans = answers_due.pop_front();
               check_field("ok", RES_W'(ans.ok), RES_W'(rsp_ok));
               check_field("first_free_id", ans.first_id, rsp_first_free_id);
               check_field("best_free_id", ans.best_id, rsp_best_free_id);
               check_field("free_total", RES_W'(ans.free_n), RES_W'(rsp_free_total));
               check_field("occupied_total", RES_W'(ans.occ_n), RES_W'(rsp_occupied_total));
               check_field("reserved_total", RES_W'(ans.res_n), RES_W'(rsp_reserved_total));
               check_field("ids_unique", RES_W'(ans.uniq), RES_W'(rsp_ids_unique));
               compared_n++;
            end
         end
         if (req_valid && req_ready) begin
            it.mode   = mode_type'(req_mode);
            it.index  = req_entry_index;
            it.id     = req_seat_id;
            it.cls    = req_class_code;
            it.col    = req_column_code;
            it.status = req_status_code;
            step_table(it, ans);
            answers_due.push_back(ans);
         end
      end
      fail_count <= misses;
      backlog    <= answers_due.size();
      compared   <= compared_n;
   end

endmodule

// File: sim/tb_class_seat_table_allocator_unit.sv
// ----------------------------------------------------------------------------
// tb_class_seat_table_allocator_unit: stimulus and verdict for the allocator
// Drives load, reserve, release and query beats with random pacing on both
// channels, retunes the two registers between idle phases, and leaves the
// prediction and comparison to seat_table_watch.
// ----------------------------------------------------------------------------
module tb_class_seat_table_allocator_unit;
   import cst_pkg::*;

   localparam int HALF_PERIOD    = 10;
   localparam int RESET_CYCLES   = 11;
   localparam int ITEM_TARGET    = 280;
   // the guard sits well above the longest 64 entry walk
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES  = 3000;

   localparam logic [CLASS_W-1:0]  CLASS_ECONOMY  = 2'd0;
   localparam logic [CLASS_W-1:0]  CLASS_BUSINESS = 2'd1;
   localparam logic [CLASS_W-1:0]  CLASS_FIRST    = 2'd2;
   localparam logic [CLASS_W-1:0]  CLASS_SPARE    = 2'd3;
   localparam logic [STATUS_W-1:0] STATUS_SPARE   = 2'd3;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic [MODE_W-1:0]         req_mode;
   logic [INDEX_W-1:0]        req_entry_index;
   logic [ID_W-1:0]           req_seat_id;
   logic [CLASS_W-1:0]        req_class_code;
   logic [COL_W-1:0]          req_column_code;
   logic [STATUS_W-1:0]       req_status_code;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic                      rsp_ok;
   logic signed [RES_W-1:0]   rsp_first_free_id;
   logic signed [RES_W-1:0]   rsp_best_free_id;
   logic [ACT_W-1:0]          rsp_free_total;
   logic [ACT_W-1:0]          rsp_occupied_total;
   logic [ACT_W-1:0]          rsp_reserved_total;
   logic                      rsp_ids_unique;
   logic                      psel;
   logic                      penable;
   logic                      pwrite;
   logic [CSR_ADDR_W-1:0]     paddr;
   logic [CSR_DATA_W-1:0]     pwdata;
   logic [CSR_DATA_W-1:0]     prdata;
   logic                      pready;

   int fail_count;
   int backlog;
   int compared;

   // stimulus-side knowledge of the table: which entries hold data and their ids,
   // so reserve/release beats can aim at ids that really exist
   bit               loaded [MAX_SEATS];
   logic [ID_W-1:0]  known_id [MAX_SEATS];
   int               active_now = 0;
   bit               calm = 1'b0;
   int unsigned      hold_left = 0;

   int items_sent = 0;
   int loads_sent = 0;
   int reserves_sent = 0;
   int releases_sent = 0;
   int queries_sent = 0;
   int settings_used = 0;

   always #HALF_PERIOD clock = ~clock;

   class_seat_table_allocator_unit DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_mode           (req_mode),
      .req_entry_index    (req_entry_index),
      .req_seat_id        (req_seat_id),
      .req_class_code     (req_class_code),
      .req_column_code    (req_column_code),
      .req_status_code    (req_status_code),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_ok             (rsp_ok),
      .rsp_first_free_id  (rsp_first_free_id),
      .rsp_best_free_id   (rsp_best_free_id),
      .rsp_free_total     (rsp_free_total),
      .rsp_occupied_total (rsp_occupied_total),
      .rsp_reserved_total (rsp_reserved_total),
      .rsp_ids_unique     (rsp_ids_unique),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   seat_table_watch u_watch (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_mode           (req_mode),
      .req_entry_index    (req_entry_index),
      .req_seat_id        (req_seat_id),
      .req_class_code     (req_class_code),
      .req_column_code    (req_column_code),
      .req_status_code    (req_status_code),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_ok             (rsp_ok),
      .rsp_first_free_id  (rsp_first_free_id),
      .rsp_best_free_id   (rsp_best_free_id),
      .rsp_free_total     (rsp_free_total),
      .rsp_occupied_total (rsp_occupied_total),
      .rsp_reserved_total (rsp_reserved_total),
      .rsp_ids_unique     (rsp_ids_unique),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .pready             (pready),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .fail_count         (fail_count),
      .backlog            (backlog),
      .compared           (compared)
   );

   // idle length: mostly short, now and then a long stretch
   function automatic int unsigned idle_span();
      if ($urandom_range(0, 99) < 85) return $urandom_range(0, 3);
      return $urandom_range(10, 60);
   endfunction

   // small id pool gives duplicates and reserve/release hits, plus the extremes
   function automatic logic [ID_W-1:0] pick_id();
      int r;
      r = $urandom_range(0, 9);
      if (r < 5) return $urandom_range(0, 15);
      if (r < 9) return $urandom();
      return $urandom_range(0, 1) ? '1 : '0;
   endfunction

   function automatic logic [CLASS_W-1:0] pick_class();
      if ($urandom_range(0, 9) == 0) return CLASS_SPARE;
      return $urandom_range(0, 2);
   endfunction

   function automatic logic [STATUS_W-1:0] pick_status();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return STATUS_FREE;
      if (r < 60) return STATUS_OCCUPIED;
      if (r < 90) return STATUS_RESERVED;
      return STATUS_SPARE;
   endfunction

   // mostly sensible columns, some anywhere in the byte, some just below 'A'
   function automatic logic [COL_W-1:0] pick_col();
      int r;
      logic [COL_W-1:0] step;
      r = $urandom_range(0, 9);
      step = $urandom_range(0, 15);
      if (r < 7) return COL_BASE + step;
      if (r < 9) return $urandom_range(0, 255);
      return COL_BASE - step - 1;
   endfunction

   // receiver: random stalls on rsp_ready, no new stall starts while calm
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!calm && $urandom_range(0, 99) < 20) begin
         rsp_ready <= 1'b0;
         hold_left <= idle_span();
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // one beat on the item channel; valid stays up until the handshake
   task automatic send_item(mode_type m, logic [INDEX_W-1:0] idx, logic [ID_W-1:0] id,
                            logic [CLASS_W-1:0] cls, logic [COL_W-1:0] col,
                            logic [STATUS_W-1:0] st);
      int unsigned gap;
      gap = 0;
      if (!calm && $urandom_range(0, 2) == 0) gap = idle_span() + 1;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_mode        <= m;
      req_entry_index <= idx;
      req_seat_id     <= id;
      req_class_code  <= cls;
      req_column_code <= col;
      req_status_code <= st;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      case (m)
         MODE_LOAD: begin
            loads_sent++;
            loaded[idx] = 1'b1;
            known_id[idx] = id;
         end
         MODE_RESERVE: reserves_sent++;
         MODE_RELEASE: releases_sent++;
         default:      queries_sent++;
      endcase
   endtask

   // sender holds off until every outstanding result has come back
   task automatic wait_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (backlog != 0);
   endtask

   // register write only with the block idle: setup cycle, then access cycle
   task automatic write_reg(logic sel, logic [CSR_DATA_W-1:0] value);
      wait_drain();
      repeat (4) @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {sel, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (sel == REG_ACTIVE_COUNT) begin
         active_now = (int'(value[ACT_W-1:0]) > MAX_SEATS) ? MAX_SEATS
                                                           : int'(value[ACT_W-1:0]);
      end
   endtask

   // one random beat for a table with n active entries
   task automatic random_item(int n);
      int r;
      int top_idx;
      logic [ID_W-1:0] id;
      r = $urandom_range(0, 99);
      top_idx = (n + 3 > MAX_SEATS - 1) ? MAX_SEATS - 1 : n + 3;
      id = (n > 0 && $urandom_range(0, 4) != 0) ? known_id[$urandom_range(0, n - 1)]
                                                : pick_id();
      if (r < 25) begin
         send_item(MODE_LOAD, $urandom_range(0, top_idx), pick_id(), pick_class(),
                   pick_col(), pick_status());
      end else if (r < 55) begin
         send_item(MODE_RESERVE, $urandom(), id, pick_class(), $urandom(), $urandom());
      end else if (r < 80) begin
         send_item(MODE_RELEASE, $urandom(), id, pick_class(), $urandom(), $urandom());
      end else if (r < 92) begin
         send_item(MODE_QUERY, $urandom(), $urandom(), pick_class(), $urandom(), $urandom());
      end else begin
         // noise: every field anywhere in its range
         send_item(mode_type'($urandom_range(0, 3)), $urandom(), $urandom(),
                   $urandom_range(0, 3), $urandom(), $urandom_range(0, 3));
      end
   endtask

   // watchdog: ends the run when no beat moves for too long
   initial begin
      int quiet;
      quiet = 0;
      do begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end while (quiet < WATCHDOG_LIMIT);
      $display("no beat for %0d cycles, %0d results outstanding", WATCHDOG_LIMIT, backlog);
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      int target;
      int eff;
      int r;
      int batch;
      logic [SPR_W-1:0] spr;
      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = MODE_LOAD;
      req_entry_index = '0;
      req_seat_id = '0;
      req_class_code = '0;
      req_column_code = '0;
      req_status_code = '0;
      rsp_ready = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part ----
      // empty table: reserve, release and query all fail, searches find nothing
      write_reg(REG_ACTIVE_COUNT, 0);
      settings_used++;
      send_item(MODE_QUERY, 0, 0, CLASS_ECONOMY, 0, STATUS_FREE);
      send_item(MODE_RESERVE, 0, 0, CLASS_ECONOMY, 0, STATUS_FREE);
      send_item(MODE_RELEASE, 0, 0, CLASS_ECONOMY, 0, STATUS_FREE);

      // eight entries with extreme ids and columns, spare class and status,
      // a column below 'A' and a duplicated id
      send_item(MODE_LOAD, 0, 100, CLASS_ECONOMY, COL_BASE, STATUS_FREE);
      send_item(MODE_LOAD, 1, 16'hFFFF, CLASS_ECONOMY, 8'hFF, STATUS_FREE);
      send_item(MODE_LOAD, 2, 0, CLASS_BUSINESS, 8'h00, STATUS_FREE);
      send_item(MODE_LOAD, 3, 100, CLASS_BUSINESS, COL_BASE + 3, STATUS_RESERVED);
      send_item(MODE_LOAD, 4, 7, CLASS_FIRST, COL_BASE + 2, STATUS_OCCUPIED);
      send_item(MODE_LOAD, 5, 8, CLASS_SPARE, COL_BASE + 1, STATUS_SPARE);
      send_item(MODE_LOAD, 6, 9, CLASS_FIRST, COL_BASE - 1, STATUS_FREE);
      send_item(MODE_LOAD, 7, 10, CLASS_SPARE, COL_BASE + 5, STATUS_FREE);

      write_reg(REG_ACTIVE_COUNT, 8);
      settings_used++;
      send_item(MODE_QUERY, 0, 0, CLASS_ECONOMY, 0, STATUS_FREE);
      send_item(MODE_QUERY, 0, 0, CLASS_BUSINESS, 0, STATUS_FREE);
      send_item(MODE_QUERY, 0, 0, CLASS_FIRST, 0, STATUS_FREE);
      send_item(MODE_QUERY, 0, 0, CLASS_SPARE, 0, STATUS_FREE);
      // reserve hits the first id 100, a second try finds it already reserved
      send_item(MODE_RESERVE, 0, 100, CLASS_ECONOMY, 0, STATUS_FREE);
      send_item(MODE_RESERVE, 0, 100, CLASS_ECONOMY, 0, STATUS_FREE);
      send_item(MODE_RELEASE, 0, 100, CLASS_ECONOMY, 0, STATUS_FREE);
      // wrong status for release, unknown id, occupied seat
      send_item(MODE_RELEASE, 0, 16'hFFFF, CLASS_ECONOMY, 0, STATUS_FREE);
      send_item(MODE_RESERVE, 0, 12345, CLASS_BUSINESS, 0, STATUS_FREE);
      send_item(MODE_RELEASE, 0, 7, CLASS_FIRST, 0, STATUS_FREE);

      // no seats per row gives no best seat, then the widest and narrowest rows
      write_reg(REG_SEATS_PER_ROW, 0);
      send_item(MODE_QUERY, 0, 0, CLASS_ECONOMY, 0, STATUS_FREE);
      write_reg(REG_SEATS_PER_ROW, 31);
      send_item(MODE_QUERY, 0, 0, CLASS_BUSINESS, 0, STATUS_FREE);
      write_reg(REG_SEATS_PER_ROW, 1);
      send_item(MODE_QUERY, 0, 0, CLASS_FIRST, 0, STATUS_FREE);
      settings_used += 3;

      // ---- random phases ----
      // each phase picks a table size and row width; most tables stay small
      // since every beat walks the whole table
      while (items_sent < ITEM_TARGET) begin
         r = $urandom_range(0, 99);
         if (settings_used == 5) target = 127;        // saturates to a full table
         else if (settings_used == 6) target = MAX_SEATS;
         else if (r < 5) target = 0;
         else if (r < 70) target = $urandom_range(1, 12);
         else if (r < 88) target = $urandom_range(13, 32);
         else if (r < 95) target = MAX_SEATS;
         else target = $urandom_range(65, 127);
         eff = (target > MAX_SEATS) ? MAX_SEATS : target;

         // every entry that becomes active must hold data first
         for (int i = 0; i < eff; i++) begin
            if (!loaded[i]) send_item(MODE_LOAD, i, pick_id(), pick_class(), pick_col(),
                                      pick_status());
         end

         r = $urandom_range(0, 99);
         if (r < 10) spr = 0;
         else if (r < 20) spr = 31;
         else spr = $urandom_range(1, 20);
         write_reg(REG_ACTIVE_COUNT, target);
         write_reg(REG_SEATS_PER_ROW, spr);
         settings_used++;

         calm = ($urandom_range(0, 3) == 0);
         batch = (eff > 32) ? $urandom_range(3, 6) : $urandom_range(8, 24);
         repeat (batch) begin
            random_item(active_now);
            if ($urandom_range(0, 29) == 0) wait_drain();
         end
      end

      // drain, then give any stray beat time to show up
      calm = 1'b0;
      wait_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d items: %0d loads, %0d reserves, %0d releases, %0d queries",
               items_sent, loads_sent, reserves_sent, releases_sent, queries_sent);
      $display("%0d register settings, %0d results compared, %0d mismatches",
               settings_used, compared, fail_count);
      if (fail_count == 0 && backlog == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
